/* hw/rtl/mel_pkg.sv */
// Shared constants and types for the midpoint ellipse rasterizer.
// No dependencies; used by mel_cfg and the top level.
package mel_pkg;

    // Default coordinate width (center and radius fields).
    localparam int COORD_BITS_DEF = 12;

    // Configuration port geometry.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register indexes (paddr[2]).
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Input opcodes (tuser of the input stream).
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Result status (tuser of the output stream).
    localparam logic STAT_POINTS = 1'b0;
    localparam logic STAT_REJECT = 1'b1;

    // Walk phase of the running ellipse.
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_R1   = 3'b010,
        PH_R2   = 3'b100
    } t_phase;

    // Sequencer states.
    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_DECODE = 13'b0000000000010,
        ST_S1     = 13'b0000000000100,
        ST_S2     = 13'b0000000001000,
        ST_S3     = 13'b0000000010000,
        ST_SQ     = 13'b0000000100000,
        ST_R1     = 13'b0000001000000,
        ST_R2     = 13'b0000010000000,
        ST_R3     = 13'b0000100000000,
        ST_R4     = 13'b0001000000000,
        ST_R5     = 13'b0010000000000,
        ST_RQ     = 13'b0100000000000,
        ST_EMIT   = 13'b1000000000000
    } t_seq_state;

endpackage

/* hw/rtl/mel_mul.sv */
// Shared unsigned multiplier with registered product.
// Depends on nothing; instanced once by the top level.
module mel_mul #(
    parameter int AW = 28,
    parameter int BW = 24
) (
    input  logic               i_clk,
    input  logic [AW-1:0]      i_a,
    input  logic [BW-1:0]      i_b,
    output logic [AW+BW-1:0]   o_prod
);

    logic [AW+BW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

/* hw/rtl/mel_cfg.sv */
// Frame size registers behind an APB-style port.
// Depends on mel_pkg for register indexes and port widths.
module mel_cfg #(
    parameter int FW = 13
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mel_pkg::APB_AW-1:0]  paddr,
    input  logic [mel_pkg::APB_DW-1:0]  pwdata,
    output logic [mel_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output logic [FW-1:0]               o_frame_width,
    output logic [FW-1:0]               o_frame_height
);

    localparam logic [FW-1:0] FRAME_RST = FW'(1) << (FW - 1);

    logic [FW-1:0] r_frame_width;
    logic [FW-1:0] r_frame_height;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_RST;
            r_frame_height <= FRAME_RST;
        end else if (wr_en) begin
            case (paddr[2])
                mel_pkg::REG_FRAME_WIDTH:  r_frame_width  <= pwdata[FW-1:0];
                mel_pkg::REG_FRAME_HEIGHT: r_frame_height <= pwdata[FW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            mel_pkg::REG_FRAME_WIDTH:
                prdata = {{(mel_pkg::APB_DW-FW){1'b0}}, r_frame_width};
            mel_pkg::REG_FRAME_HEIGHT:
                prdata = {{(mel_pkg::APB_DW-FW){1'b0}}, r_frame_height};
            default:
                prdata = '0;
        endcase
    end

    assign o_frame_width  = r_frame_width;
    assign o_frame_height = r_frame_height;

endmodule

/* hw/rtl/midpoint_ellipse_rasterizer_top.sv */
// Midpoint ellipse rasterizer: sequencer, walk datapath and output register.
// Depends on mel_pkg, mel_mul (shared multiplier) and mel_cfg (frame registers).
//
//  Channel   Dir  Handshake                    Payload
//  s_axis    in   tvalid/tready                tuser=opcode, tdata=cx,cy,rx,ry,fill,color
//  m_axis    out  tvalid/tready                tuser=status, tlast=last_set,
//                                              tdata=left,right,top,bottom,span,color
//  apb       in   psel/penable/pwrite/pready   paddr 4*i, pwdata/prdata 32 bits
//
//  Sequencing: one beat is worked at a time. A plain step is accepted, then updated and
//  emitted; a rejected start likewise. An accepted start runs three products on the
//  shared multiplier plus a rounding state. The step that crosses into region 2 runs
//  five serial products, rounding, then the emit.
//  Reset (synchronous, active low) clears sequencer, phase and output valid; frame
//  registers return to 2^COORD_BITS. A waiting result stalls input unless taken that cycle.
module midpoint_ellipse_rasterizer_top #(
    parameter  int COORD_BITS = mel_pkg::COORD_BITS_DEF,
    localparam int IN_W  = ((4 * COORD_BITS + 33 + 7) / 8) * 8,
    localparam int OUT_W = ((4 * (COORD_BITS + 2) + 33 + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input stream
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // tdata, low bit up: center_x, center_y, radius_x, radius_y, fill_mode,
    // pixel_color, zero pad
    input  logic [IN_W-1:0]             i_s_axis_tdata,
    // tuser: opcode
    input  logic                        i_s_axis_tuser,
    // result stream
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // tdata, low bit up: left_col, right_col, top_row, bottom_row, span_valid,
    // out_color, zero pad
    output logic [OUT_W-1:0]            o_m_axis_tdata,
    // tuser: status
    output logic                        o_m_axis_tuser,
    // tlast: last_set
    output logic                        o_m_axis_tlast,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mel_pkg::APB_AW-1:0]  paddr,
    input  logic [mel_pkg::APB_DW-1:0]  pwdata,
    output logic [mel_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    localparam int C  = COORD_BITS;
    localparam int XW = C + 1;        // x offset, frame size
    localparam int YW = C + 2;        // signed y offset, output coordinates
    localparam int QW = 2 * C;        // squared radii
    localparam int SW = 3 * C + 4;    // slope terms
    localparam int DW = 4 * C + 4;    // decision, accumulator, product
    localparam int AW = 2 * C + 4;    // multiplier operand a
    localparam int BW = 2 * C;        // multiplier operand b
    localparam int OPAD = OUT_W - (4 * YW + 33);
    localparam int IDATA = 4 * C + 33;

    // ---------------------------------------------------------------------
    // Frame registers
    // ---------------------------------------------------------------------
    logic [XW-1:0] frame_width;
    logic [XW-1:0] frame_height;

    mel_cfg #(.FW(XW)) u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_frame_width  (frame_width),
        .o_frame_height (frame_height)
    );

    // ---------------------------------------------------------------------
    // State
    // ---------------------------------------------------------------------
    mel_pkg::t_seq_state r_state;
    mel_pkg::t_phase     r_phase;

    // input beat latch
    logic                r_op;
    logic [C-1:0]        r_cx, r_cy, r_rx, r_ry;
    logic                r_fill;
    logic [31:0]         r_color;

    // held ellipse
    logic [C-1:0]        r_hcx, r_hcy;
    logic                r_hfill;
    logic [31:0]         r_hcolor;
    logic [QW-1:0]       r_rx2, r_ry2;

    // walk
    logic [XW-1:0]          r_x;
    logic signed [YW-1:0]   r_y;
    logic signed [SW-1:0]   r_sx, r_sy;
    logic signed [DW-1:0]   r_dec;
    logic signed [DW-1:0]   r_acc;

    // output register
    logic                r_ov;
    logic                r_ostat;
    logic [YW-1:0]       r_left, r_right, r_top, r_bottom;
    logic                r_span;
    logic [31:0]         r_ocolor;
    logic                r_olast;

    logic in_acc;
    assign o_s_axis_tready = (r_state == mel_pkg::ST_IDLE) && (!r_ov || i_m_axis_tready);
    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // ---------------------------------------------------------------------
    // Shared multiplier
    // ---------------------------------------------------------------------
    logic [AW-1:0] mul_a;
    logic [BW-1:0] mul_b;
    logic [DW-1:0] prod;

    mel_mul #(.AW(AW), .BW(BW)) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    logic [C+1:0] tx;     // 2x+1
    logic [XW-1:0] ym;    // |y-1|, y is never negative in region 1
    assign tx = {r_x, 1'b1};
    assign ym = (r_y == '0) ? XW'(1) : XW'(r_y - YW'(1));

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            mel_pkg::ST_DECODE: begin
                if (r_op == mel_pkg::OP_START) begin
                    mul_a = {{(AW-C){1'b0}}, r_rx};
                    mul_b = {{(BW-C){1'b0}}, r_rx};
                end else begin
                    mul_a = {{(AW-C-2){1'b0}}, tx};
                    mul_b = {{(BW-C-2){1'b0}}, tx};
                end
            end
            mel_pkg::ST_S1: begin
                mul_a = {{(AW-C){1'b0}}, r_ry};
                mul_b = {{(BW-C){1'b0}}, r_ry};
            end
            mel_pkg::ST_S2: begin
                mul_a = {{(AW-C){1'b0}}, r_ry};
                mul_b = r_rx2;
            end
            mel_pkg::ST_R1: begin
                mul_a = prod[AW-1:0];          // (2x+1)^2
                mul_b = r_ry2;
            end
            mel_pkg::ST_R2: begin
                mul_a = {{(AW-XW){1'b0}}, ym};
                mul_b = {{(BW-XW){1'b0}}, ym};
            end
            mel_pkg::ST_R3: begin
                mul_a = prod[AW-1:0];          // (y-1)^2
                mul_b = r_rx2;
            end
            mel_pkg::ST_R4: begin
                mul_a = {{(AW-QW){1'b0}}, r_ry2};
                mul_b = r_rx2;
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------------
    // Step datapath
    // ---------------------------------------------------------------------
    logic signed [DW-1:0] prod_x4;
    logic signed [DW-1:0] rx2_d, ry2_d;
    logic signed [SW-1:0] sx_inc, sy_dec;
    logic signed [DW-1:0] sx_inc_d, sy_dec_d;
    logic signed [DW-1:0] acc_bias, quarter;
    logic                 dec_neg, dec_pos, switch_r2, start_bad;

    assign prod_x4  = signed'({prod[DW-3:0], 2'b00});
    assign rx2_d    = signed'({{(DW-QW){1'b0}}, r_rx2});
    assign ry2_d    = signed'({{(DW-QW){1'b0}}, r_ry2});
    assign sx_inc   = r_sx + signed'({{(SW-QW-1){1'b0}}, r_ry2, 1'b0});
    assign sy_dec   = r_sy - signed'({{(SW-QW-1){1'b0}}, r_rx2, 1'b0});
    assign sx_inc_d = {{(DW-SW){sx_inc[SW-1]}}, sx_inc};
    assign sy_dec_d = {{(DW-SW){sy_dec[SW-1]}}, sy_dec};
    assign dec_neg  = r_dec[DW-1];
    assign dec_pos  = !r_dec[DW-1] && (r_dec != '0);

    // divide by four toward zero: bias negatives by 3, then arithmetic shift
    assign acc_bias = r_acc + signed'({{(DW-2){1'b0}}, {2{r_acc[DW-1]}}});
    assign quarter  = {{2{acc_bias[DW-1]}}, acc_bias[DW-1:2]};

    assign switch_r2 = (r_phase == mel_pkg::PH_R1) && !(r_sx < r_sy);

    assign start_bad = ({1'b0, r_cx} + {1'b0, r_rx} >= frame_width)
                    || ({1'b0, r_cy} + {1'b0, r_ry} >= frame_height)
                    || (r_cx < r_rx) || (r_cy < r_ry);

    // next walk values for an emitted point set
    logic [XW-1:0]        n_x;
    logic signed [YW-1:0] n_y;
    logic signed [SW-1:0] n_sx, n_sy;
    logic signed [DW-1:0] n_dec;
    logic                 n_last;

    always_comb begin
        n_x   = r_x;
        n_y   = r_y;
        n_sx  = r_sx;
        n_sy  = r_sy;
        n_dec = r_dec;
        if (r_phase == mel_pkg::PH_R1) begin
            n_x  = r_x + XW'(1);
            n_sx = sx_inc;
            if (dec_neg) begin
                n_dec = r_dec + ry2_d + sx_inc_d;
            end else begin
                n_y   = r_y - YW'(1);
                n_sy  = sy_dec;
                n_dec = r_dec + ry2_d + sx_inc_d - sy_dec_d;
            end
        end else begin
            n_y  = r_y - YW'(1);
            n_sy = sy_dec;
            if (dec_pos) begin
                n_dec = r_dec + rx2_d - sy_dec_d;
            end else begin
                n_x   = r_x + XW'(1);
                n_sx  = sx_inc;
                n_dec = r_dec + rx2_d - sy_dec_d + sx_inc_d;
            end
        end
        n_last = (r_phase == mel_pkg::PH_R2) && n_y[YW-1];
    end

    logic do_emit, do_reject;
    assign do_emit = (r_state == mel_pkg::ST_EMIT)
                  || ((r_state == mel_pkg::ST_DECODE) && (r_op == mel_pkg::OP_STEP)
                      && (r_phase != mel_pkg::PH_IDLE) && !switch_r2);
    assign do_reject = (r_state == mel_pkg::ST_DECODE) && (r_op == mel_pkg::OP_START)
                    && start_bad;

    // ---------------------------------------------------------------------
    // Sequencer and control state
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mel_pkg::ST_IDLE;
            r_phase <= mel_pkg::PH_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (do_emit || do_reject) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
            if (do_emit && n_last) begin
                r_phase <= mel_pkg::PH_IDLE;
            end
            case (r_state)
                mel_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        r_state <= mel_pkg::ST_DECODE;
                    end
                end
                mel_pkg::ST_DECODE: begin
                    if (r_op == mel_pkg::OP_START) begin
                        r_phase <= mel_pkg::PH_IDLE;
                        r_state <= start_bad ? mel_pkg::ST_IDLE : mel_pkg::ST_S1;
                    end else if (switch_r2) begin
                        r_state <= mel_pkg::ST_R1;
                    end else begin
                        r_state <= mel_pkg::ST_IDLE;
                    end
                end
                mel_pkg::ST_S1: r_state <= mel_pkg::ST_S2;
                mel_pkg::ST_S2: r_state <= mel_pkg::ST_S3;
                mel_pkg::ST_S3: r_state <= mel_pkg::ST_SQ;
                mel_pkg::ST_SQ: begin
                    r_phase <= mel_pkg::PH_R1;
                    r_state <= mel_pkg::ST_IDLE;
                end
                mel_pkg::ST_R1: r_state <= mel_pkg::ST_R2;
                mel_pkg::ST_R2: r_state <= mel_pkg::ST_R3;
                mel_pkg::ST_R3: r_state <= mel_pkg::ST_R4;
                mel_pkg::ST_R4: r_state <= mel_pkg::ST_R5;
                mel_pkg::ST_R5: r_state <= mel_pkg::ST_RQ;
                mel_pkg::ST_RQ: begin
                    r_phase <= mel_pkg::PH_R2;
                    r_state <= mel_pkg::ST_EMIT;
                end
                mel_pkg::ST_EMIT: r_state <= mel_pkg::ST_IDLE;
                default: r_state <= mel_pkg::ST_IDLE;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Datapath registers (no reset)
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op    <= i_s_axis_tuser;
            r_cx    <= i_s_axis_tdata[C-1:0];
            r_cy    <= i_s_axis_tdata[2*C-1:C];
            r_rx    <= i_s_axis_tdata[3*C-1:2*C];
            r_ry    <= i_s_axis_tdata[4*C-1:3*C];
            r_fill  <= i_s_axis_tdata[4*C];
            r_color <= i_s_axis_tdata[IDATA-1:4*C+1];
        end

        case (r_state)
            mel_pkg::ST_DECODE: begin
                if (r_op == mel_pkg::OP_START) begin
                    r_hcx    <= r_cx;
                    r_hcy    <= r_cy;
                    r_hfill  <= r_fill;
                    r_hcolor <= r_color;
                end
            end
            mel_pkg::ST_S1: r_rx2 <= prod[QW-1:0];
            mel_pkg::ST_S2: begin
                r_ry2 <= prod[QW-1:0];
                r_acc <= prod_x4 + rx2_d;          // 4*ry2 + rx2
            end
            mel_pkg::ST_S3: begin
                r_acc <= r_acc - prod_x4;          // - 4*rx2*ry
                r_sy  <= signed'({prod[SW-2:0], 1'b0});
            end
            mel_pkg::ST_SQ: begin
                r_dec <= quarter;
                r_x   <= '0;
                r_y   <= signed'({2'b00, r_ry});
                r_sx  <= '0;
            end
            mel_pkg::ST_R2: r_acc <= signed'(prod);              // ry2*(2x+1)^2
            mel_pkg::ST_R4: r_acc <= r_acc + prod_x4;            // + 4*rx2*(y-1)^2
            mel_pkg::ST_R5: r_acc <= r_acc - prod_x4;            // - 4*rx2*ry2
            mel_pkg::ST_RQ: r_dec <= quarter;
            default: ;
        endcase

        if (do_emit) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_sx  <= n_sx;
            r_sy  <= n_sy;
            r_dec <= n_dec;

            r_ostat  <= mel_pkg::STAT_POINTS;
            r_left   <= YW'({2'b00, r_hcx}) - YW'({1'b0, r_x});
            r_right  <= YW'({2'b00, r_hcx}) + YW'({1'b0, r_x});
            r_top    <= YW'({2'b00, r_hcy}) - YW'(r_y);
            r_bottom <= YW'({2'b00, r_hcy}) + YW'(r_y);
            r_span   <= r_hfill && (r_x != '0);
            r_ocolor <= r_hcolor;
            r_olast  <= n_last;
        end else if (do_reject) begin
            r_ostat  <= mel_pkg::STAT_REJECT;
            r_left   <= '0;
            r_right  <= '0;
            r_top    <= '0;
            r_bottom <= '0;
            r_span   <= 1'b0;
            r_ocolor <= '0;
            r_olast  <= 1'b0;
        end
    end

    // ---------------------------------------------------------------------
    // Result stream
    // ---------------------------------------------------------------------
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tuser  = r_ostat;
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tdata  = {{OPAD{1'b0}}, r_ocolor, r_span,
                              r_bottom, r_top, r_right, r_left};

endmodule

/* tb/sv/midpoint_ellipse_rasterizer_top_tb.sv */
`timescale 1ns / 100ps
// Testbench for midpoint_ellipse_rasterizer_top: random-stall stream driving, APB frame setup,
// and a scoreboard that predicts each point set. Depends on mel_pkg and the rasterizer RTL.
module midpoint_ellipse_rasterizer_top_tb;
    import mel_pkg::*;

    localparam int CB    = COORD_BITS_DEF;
    localparam int OW    = CB + 2;                          // signed output coordinate width
    localparam int IN_W  = ((4 * CB + 33 + 7) / 8) * 8;
    localparam int OUT_W = ((4 * OW + 33 + 7) / 8) * 8;

    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int SETTLE_CYCLES = 24;    // covers a start or the region change plus margin
    localparam int STALL_LIMIT   = 4000;  // cycles with no beat, APB access or result

    // One command beat on the input stream.
    typedef struct packed {
        logic          op;
        logic [CB-1:0] cx;
        logic [CB-1:0] cy;
        logic [CB-1:0] rx;
        logic [CB-1:0] ry;
        logic          fill;
        logic [31:0]   color;
    } ellipse_cmd_t;

    // One point set (or reject) on the result stream.
    typedef struct packed {
        logic          status;
        logic [OW-1:0] left;
        logic [OW-1:0] right;
        logic [OW-1:0] top;
        logic [OW-1:0] bottom;
        logic          span;
        logic [31:0]   color;
        logic          last;
    } point_set_t;

    // Scoreboard: tracks the ellipse walk and queues the point sets it predicts.
    class ellipse_walk_sb;
        logic [63:0]  frame_w, frame_h;
        t_phase       walk;
        logic [63:0]  off_x, off_y, gx, gy, dec, rx_sq, ry_sq, ctr_x, ctr_y;
        logic         fill;
        logic [31:0]  color;
        point_set_t   sets[$];
        int           errors, n_starts, n_rejects, n_checked, n_done;

        function new();
            frame_w = 64'd4096;
            frame_h = 64'd4096;
            walk    = PH_IDLE;
        endfunction

        function void set_frame(logic reg_idx, logic [31:0] value);
            if (reg_idx == REG_FRAME_WIDTH) frame_w = 64'(value & 32'h1FFF);
            else frame_h = 64'(value & 32'h1FFF);
        endfunction

        function bit busy();
            return walk != PH_IDLE;
        endfunction

        function int pending();
            return sets.size();
        endfunction

        // Signed divide by 4, truncating toward zero.
        function logic [63:0] quarter(logic [63:0] v);
            if (v[63]) return 64'd0 - ((64'd0 - v) >> 2);
            return v >> 2;
        endfunction

        function void note_cmd(ellipse_cmd_t c);
            point_set_t  s;
            logic [63:0] cx, cy, rx, ry, tx, ym;
            s = '0;
            if (c.op == OP_START) begin
                cx   = 64'(c.cx);
                cy   = 64'(c.cy);
                rx   = 64'(c.rx);
                ry   = 64'(c.ry);
                walk = PH_IDLE;
                if (cx + rx >= frame_w || cy + ry >= frame_h || cx < rx || cy < ry) begin
                    s.status = STAT_REJECT;
                    sets.push_back(s);
                    n_rejects++;
                    return;
                end
                rx_sq = rx * rx;
                ry_sq = ry * ry;
                ctr_x = cx;
                ctr_y = cy;
                fill  = c.fill;
                color = c.color;
                off_x = 64'd0;
                off_y = ry;
                gx    = 64'd0;
                gy    = 2 * rx_sq * ry;
                dec   = quarter(4 * ry_sq - 4 * rx_sq * ry + rx_sq);
                walk  = PH_R1;
                n_starts++;
                return;
            end
            if (walk == PH_IDLE) return;   // step with no ellipse running

            // slope reached -1: reseed the decision term for region 2
            if (walk == PH_R1 && !($signed(gx) < $signed(gy))) begin
                tx   = 2 * off_x + 1;
                ym   = off_y - 1;
                dec  = quarter(ry_sq * tx * tx + 4 * rx_sq * ym * ym - 4 * rx_sq * ry_sq);
                walk = PH_R2;
            end
            s.status = STAT_POINTS;
            s.left   = OW'(ctr_x - off_x);
            s.right  = OW'(ctr_x + off_x);
            s.top    = OW'(ctr_y - off_y);
            s.bottom = OW'(ctr_y + off_y);
            s.span   = fill && off_x != 0;
            s.color  = color;
            if (walk == PH_R1) begin
                off_x += 1;
                gx    += 2 * ry_sq;
                if (dec[63]) begin
                    dec += ry_sq + gx;
                end else begin
                    off_y -= 1;
                    gy    -= 2 * rx_sq;
                    dec   += ry_sq + gx - gy;
                end
            end else begin
                off_y -= 1;
                gy    -= 2 * rx_sq;
                if (!dec[63] && dec != 0) begin
                    dec += rx_sq - gy;
                end else begin
                    off_x += 1;
                    gx    += 2 * ry_sq;
                    dec   += rx_sq - gy + gx;
                end
                if (off_y[63]) begin
                    s.last = 1'b1;
                    walk   = PH_IDLE;
                    n_done++;
                end
            end
            sets.push_back(s);
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] seen);
            if (want !== seen) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, seen);
            end
        endfunction

        function void check_set(point_set_t got);
            point_set_t exp_set;
            if (sets.size() == 0) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: result with none expected, expected none, got %h", $time, got);
                return;
            end
            exp_set = sets.pop_front();
            n_checked++;
            cmp_field("status", 32'(exp_set.status), 32'(got.status));
            cmp_field("left_col", 32'(exp_set.left), 32'(got.left));
            cmp_field("right_col", 32'(exp_set.right), 32'(got.right));
            cmp_field("top_row", 32'(exp_set.top), 32'(got.top));
            cmp_field("bottom_row", 32'(exp_set.bottom), 32'(got.bottom));
            cmp_field("span_valid", 32'(exp_set.span), 32'(got.span));
            cmp_field("out_color", exp_set.color, got.color);
            cmp_field("last_set", 32'(exp_set.last), 32'(got.last));
        endfunction
    endclass

    // DUT-facing signals; the driven ones are known from time zero
    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              i_s_axis_tvalid  = 1'b0;
    logic              o_s_axis_tready;
    logic [IN_W-1:0]   i_s_axis_tdata   = '0;   // cx, cy, rx, ry, fill, color, pad (low bit up)
    logic              i_s_axis_tuser   = 1'b0; // opcode
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready  = 1'b0;
    logic [OUT_W-1:0]  o_m_axis_tdata;          // left, right, top, bottom, span, color, pad
    logic              o_m_axis_tuser;          // status
    logic              o_m_axis_tlast;          // last_set
    logic              psel             = 1'b0;
    logic              penable          = 1'b0;
    logic              pwrite           = 1'b0;
    logic [APB_AW-1:0] paddr            = '0;
    logic [APB_DW-1:0] pwdata           = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    ellipse_walk_sb sb;
    bit             quiet    = 1'b0;  // final stretch: no idling on either side
    bit             hold_req = 1'b0;  // asks the result sink for one long hold-off
    int             n_beats  = 0;     // start beats, and steps that advance an ellipse
    int             n_ignored = 0;    // steps sent while idle
    int             n_settings = 1;
    int             stall_count = 0;
    point_set_t     seen_set;

    midpoint_ellipse_rasterizer_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result monitor and stall watchdog. Sampling at the edge sees pre-edge values,
    // so both sides of every handshake are read as the DUT saw them.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            seen_set.status = o_m_axis_tuser;
            seen_set.last   = o_m_axis_tlast;
            seen_set.left   = o_m_axis_tdata[OW-1:0];
            seen_set.right  = o_m_axis_tdata[2*OW-1:OW];
            seen_set.top    = o_m_axis_tdata[3*OW-1:2*OW];
            seen_set.bottom = o_m_axis_tdata[4*OW-1:3*OW];
            seen_set.span   = o_m_axis_tdata[4*OW];
            seen_set.color  = o_m_axis_tdata[4*OW+32:4*OW+1];
            sb.check_set(seen_set);
        end
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (psel && penable))
            stall_count = 0;
        else
            stall_count++;
        if (stall_count >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d point sets outstanding",
                     $time, STALL_LIMIT, sb.pending());
            $display("FAIL");
            $finish;
        end
    end

    // Result sink: random ready bursts, one long hold-off on request, none when quiet.
    initial begin : result_sink
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (quiet || $urandom_range(0, 3) != 0) begin
                i_m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
        end
    end

    // Drive one command beat and wait for its acceptance; may leave a random gap after.
    task automatic send_cmd(ellipse_cmd_t c);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= c.op;
        i_s_axis_tdata  <= IN_W'({c.color, c.fill, c.ry, c.rx, c.cy, c.cx});
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (c.op == OP_STEP && !sb.busy()) n_ignored++;
        else n_beats++;
        sb.note_cmd(c);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic start_cmd(int cx, int cy, int rx, int ry, bit fill, logic [31:0] color);
        ellipse_cmd_t c;
        c = {OP_START, CB'(cx), CB'(cy), CB'(rx), CB'(ry), fill, color};
        send_cmd(c);
    endtask

    // Step beats carry random junk in the unused fields.
    task automatic step_cmd();
        ellipse_cmd_t c;
        c = {OP_STEP, CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom),
             1'($urandom), 32'($urandom)};
        send_cmd(c);
    endtask

    // Step the running ellipse to its last set, or abandon it after cap steps.
    task automatic walk(int cap);
        int n;
        n = 0;
        while (sb.busy() && n < cap) begin
            step_cmd();
            n++;
        end
    endtask

    // Idle the input, drain every expected set, then let a start or region change finish.
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_frame(logic reg_idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_frame(reg_idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly well-formed ellipses that fit the frame and run to the end; the rest
    // are abandoned walks, fully random starts (mostly rejected) and stray steps.
    task automatic random_ellipse();
        int pick, rmax, rx, ry, cx, cy, fw, fh, cap;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            step_cmd();
            return;
        end
        if (pick < 15) begin
            start_cmd($urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), $urandom_range(0, 4095),
                      1'($urandom_range(0, 1)), $urandom);
            walk($urandom_range(0, 30));
            return;
        end
        pick = $urandom_range(0, 99);
        rmax = pick < 80 ? 12 : (pick < 95 ? 60 : 2047);
        rx   = $urandom_range(0, rmax);
        ry   = $urandom_range(0, rmax);
        fw   = int'(sb.frame_w);
        fh   = int'(sb.frame_h);
        if (fw > 0) begin
            if (2 * rx + 1 > fw) rx = (fw - 1) / 2;
            cx = $urandom_range(rx, fw - 1 - rx);
        end else begin
            cx = $urandom_range(0, 4095);
        end
        if (fh > 0) begin
            if (2 * ry + 1 > fh) ry = (fh - 1) / 2;
            cy = $urandom_range(ry, fh - 1 - ry);
        end else begin
            cy = $urandom_range(0, 4095);
        end
        start_cmd(cx, cy, rx, ry, 1'($urandom_range(0, 1)), $urandom);
        if (rmax == 2047) cap = $urandom_range(1, 40);
        else if ($urandom_range(0, 7) == 0) cap = $urandom_range(0, 2 * rmax + 2);
        else cap = 1 << 30;
        walk(cap);
    endtask

    task automatic random_run(int n);
        int target;
        target = n_beats + n;
        while (n_beats < target) random_ellipse();
    endtask

    task automatic frame_phase(int w, int h, int n);
        settle();
        write_frame(REG_FRAME_WIDTH, w);
        write_frame(REG_FRAME_HEIGHT, h);
        n_settings++;
        random_run(n);
    endtask

    initial begin : stimulus
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: stray step, tiny walks, zero radii, frame-corner accepts
        step_cmd();
        start_cmd(2048, 2048, 3, 2, 1'b1, 32'hFFFF_FFFF);
        walk(1 << 30);
        start_cmd(100, 100, 0, 0, 1'b0, 32'h0000_0000);
        walk(1 << 30);
        start_cmd(4095, 0, 0, 0, 1'b1, 32'h0000_0000);
        walk(1 << 30);
        start_cmd(10, 10, 5, 0, 1'b1, 32'hA5A5_A5A5);   // flat: straight to region 2
        walk(1 << 30);
        start_cmd(0, 4095, 0, 7, 1'b1, 32'h5A5A_5A5A);   // thin vertical
        walk(1 << 30);
        // rejects on each of the four corner tests, and the widest radii
        start_cmd(4095, 100, 1, 1, 1'b1, 32'h1111_1111);
        start_cmd(0, 100, 1, 0, 1'b0, 32'h2222_2222);
        start_cmd(100, 4095, 0, 1, 1'b1, 32'h3333_3333);
        start_cmd(100, 0, 0, 1, 1'b0, 32'h4444_4444);
        start_cmd(2048, 2048, 4095, 4095, 1'b1, 32'hFFFF_FFFF);
        // big ellipse replaced mid-walk, then killed by a reject, then a stray step
        start_cmd(2048, 2047, 2047, 2047, 1'b1, 32'h1234_5678);
        walk(5);
        start_cmd(1000, 1000, 9, 14, 1'b1, 32'h8765_4321);
        walk(3);
        start_cmd(4095, 4095, 4095, 4095, 1'b0, 32'hDEAD_BEEF);
        step_cmd();
        // receiver holds off while steps keep coming: block must back-pressure
        hold_req = 1'b1;
        start_cmd(2000, 1500, 20, 15, 1'b1, 32'hC0FF_EE00);
        walk(1 << 30);

        random_run(120);
        hold_req = 1'b1;
        random_run(130);
        frame_phase(1, 1, 40);          // only a point ellipse fits
        frame_phase(0, 4096, 30);       // every start rejected
        frame_phase(4096, 1, 30);
        frame_phase(200, 120, 200);
        frame_phase(4096, 4096, 330);
        quiet = 1'b1;
        random_run(120);
        settle();

        $display("Covered %0d beats across %0d frame settings: %0d ellipses, %0d rejects,",
                 n_beats, n_settings, sb.n_starts, sb.n_rejects);
        $display("%0d point sets checked, %0d walks run to the last set, %0d idle steps.",
                 sb.n_checked, sb.n_done, n_ignored);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("FAIL");
        end
        $finish;
    end

endmodule
